>>> hdl/bilinear_current_deposit_unit_macros.svh
// Assertion macros shared by the deposit unit.
// Depends on nothing; included by the top level.
`ifndef BILINEAR_CURRENT_DEPOSIT_UNIT_MACROS_SVH
`define BILINEAR_CURRENT_DEPOSIT_UNIT_MACROS_SVH
// condition, or implication, checked on every clock unless in reset
`define BCD_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define BCD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

>>> hdl/bcd_pkg.sv
// Package for the bilinear current deposit unit: commands, status codes,
// register indexes, queue entry type. No dependencies.
package bcd_pkg;
  localparam logic [1:0] CMD_DEPOSIT = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DROP     = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_ORG_X   = 2'd0;
  localparam logic [1:0] REG_ORG_Y   = 2'd1;
  localparam logic [1:0] REG_INV_X   = 2'd2;
  localparam logic [1:0] REG_INV_Y   = 2'd3;

  typedef enum logic [1:0] {OP_DEPOSIT, OP_READ, OP_CLEAR, OP_NONE} op_t;

  // classified word handed from front to back
  typedef struct packed {
    op_t         op;
    logic        drop;
    logic [9:0]  cx;
    logic [9:0]  cy;
    logic [15:0] fx;
    logic [15:0] fy;
    logic signed [23:0] jx;
    logic signed [23:0] jy;
  } job_t;

  typedef enum logic [2:0] {B_CLR, B_IDLE, B_READ, B_WAIT, B_MUL, B_WRITE, B_OUT}
    bstate_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) sat32 = 32'h7fffffff;
    else if (v < -34'sd2147483648) sat32 = 32'h80000000;
    else sat32 = v[31:0];
  endfunction
endpackage

>>> hdl/bcd_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module bcd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> hdl/bcd_front.sv
// Front end: two-stage locate and classify of each word (multiply, then classify).
// Depends on bcd_pkg.
module bcd_front import bcd_pkg::*; #(
  parameter int BLOCK_X = 63,
  parameter int BLOCK_Y = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [23:0] current_x,
  input  logic signed [23:0] current_y,
  input  logic [5:0]  cell_x,
  input  logic [5:0]  cell_y,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic [23:0] inv_spacing_x,
  input  logic [23:0] inv_spacing_y,
  output logic        q_valid,
  input  logic        q_ready,
  output job_t        q_job
);
  // stage 1 registers
  logic s1v;
  logic [1:0] s1cmd;
  logic signed [57:0] s1sx, s1sy;
  logic signed [23:0] s1jx, s1jy;
  logic [5:0] s1cx, s1cy;
  logic signed [32:0] dx, dy;
  logic s1_ready;
  job_t j;

  assign dx = 33'(pos_x) - 33'(origin_x);
  assign dy = 33'(pos_y) - 33'(origin_y);
  assign s1_ready = !q_valid || q_ready;
  assign in_ready = !s1v || s1_ready;

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) s1v <= 1'b0;
    else if (in_ready) s1v <= in_valid;
    if (in_ready && in_valid) begin
      s1cmd <= cmd;
      s1sx  <= dx * $signed({1'b0, inv_spacing_x});
      s1sy  <= dy * $signed({1'b0, inv_spacing_y});
      s1jx  <= current_x;
      s1jy  <= current_y;
      s1cx  <= cell_x;
      s1cy  <= cell_y;
    end
  end

  // classify
  always_comb begin
    j = '0;
    j.jx = s1jx;
    j.jy = s1jy;
    case (s1cmd)
      CMD_DEPOSIT: begin
        j.op = OP_DEPOSIT;
        j.fx = s1sx[31:16];
        j.fy = s1sy[31:16];
        j.cx = s1sx[41:32];
        j.cy = s1sy[41:32];
        j.drop = s1sx[57] || s1sy[57] || (s1sx[56:32] >= 25'(BLOCK_X))
                 || (s1sy[56:32] >= 25'(BLOCK_Y));
      end
      CMD_READ, CMD_CLEAR: begin
        j.op = (s1cmd == CMD_READ) ? OP_READ : OP_CLEAR;
        j.cx = 10'(s1cx);
        j.cy = 10'(s1cy);
        j.drop = (32'(s1cx) > 32'(BLOCK_X)) || (32'(s1cy) > 32'(BLOCK_Y));
      end
      default: j.op = OP_NONE;
    endcase
  end

  // single-entry queue towards the back end
  always_ff @(posedge clk) begin
    if (rst) q_valid <= 1'b0;
    else if (s1_ready) q_valid <= s1v;
    if (s1_ready && s1v) q_job <= j;
  end
endmodule

>>> hdl/bcd_back.sv
// Back end: per-corner RMW of both grids on deposit; one result out.
// Depends on bcd_pkg and bcd_ram.
module bcd_back import bcd_pkg::*; #(
  parameter int BLOCK_X = 63,
  parameter int BLOCK_Y = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  job_t        q_job,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] read_x,
  output logic signed [31:0] read_y,
  output logic [1:0]  status
);
  localparam int GW = BLOCK_X + 1;
  localparam int DEPTH = GW * (BLOCK_Y + 1);
  localparam int AW = $clog2(DEPTH);

  bstate_t state, state_next;
  job_t job;
  logic [1:0] corner;
  logic clip;
  logic [AW-1:0] addr, rmw_addr, clr_addr;
  logic we;
  logic signed [31:0] wx, wy, rx, ry;
  logic [16:0] ax, ay;
  logic [33:0] w;
  logic signed [58:0] px, py;
  logic signed [33:0] sx, sy;
  logic signed [31:0] nx, ny;
  logic cx_hi, cy_hi;

  assign cx_hi = corner[0];
  assign cy_hi = corner[1];
  assign rmw_addr = AW'((32'(job.cy) + 32'(cy_hi)) * GW + 32'(job.cx) + 32'(cx_hi));
  assign addr = (state == B_CLR) ? clr_addr : rmw_addr;
  assign ax = cx_hi ? {1'b0, job.fx} : 17'd65536 - 17'(job.fx);
  assign ay = cy_hi ? {1'b0, job.fy} : 17'd65536 - 17'(job.fy);

  bcd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_x (
    .clk(clk), .we(we), .addr(addr), .wdata(wx), .rdata(rx));
  bcd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_y (
    .clk(clk), .we(we), .addr(addr), .wdata(wy), .rdata(ry));

  // contribution with round half up, then saturating add
  assign sx = 34'(rx) + 34'((px + 59'sh80000000) >>> 32);
  assign sy = 34'(ry) + 34'((py + 59'sh80000000) >>> 32);
  assign nx = sat32(sx);
  assign ny = sat32(sy);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_CLR:   if (clr_addr == AW'(DEPTH - 1)) state_next = B_IDLE;
      B_IDLE:  if (q_valid) begin
        if (q_job.drop || q_job.op == OP_NONE) state_next = B_OUT;
        else state_next = B_READ;
      end
      B_READ:  state_next = B_WAIT;
      B_WAIT:  state_next = (job.op == OP_DEPOSIT) ? B_MUL : B_WRITE;
      B_MUL:   state_next = B_WRITE;
      B_WRITE: state_next = (job.op != OP_DEPOSIT || corner == 2'd3) ? B_OUT : B_READ;
      B_OUT:   if (out_ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_ready = (state == B_IDLE);
    out_valid = (state == B_OUT);
    we = (state == B_CLR) || ((state == B_WRITE) && (job.op != OP_READ));
    wx = (state != B_CLR && job.op == OP_DEPOSIT) ? nx : '0;
    wy = (state != B_CLR && job.op == OP_DEPOSIT) ? ny : '0;
  end

  // clearing pass address after reset
  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (state == B_CLR) clr_addr <= clr_addr + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_CLR;
    else state <= state_next;
    case (state)
      B_IDLE: begin
        job <= q_job;
        corner <= 2'd0;
        clip <= 1'b0;
        read_x <= '0;
        read_y <= '0;
        status <= q_job.drop ? ST_DROP : ST_OK;
      end
      B_WAIT: w <= 34'(ax) * 34'(ay);
      B_MUL: begin
        px <= $signed({1'b0, w}) * 59'(job.jx);
        py <= $signed({1'b0, w}) * 59'(job.jy);
      end
      B_WRITE: begin
        if (job.op == OP_DEPOSIT) begin
          corner <= corner + 2'd1;
          if (sx != 34'(nx) || sy != 34'(ny) || clip) begin
            clip <= 1'b1;
            status <= ST_SAT;
          end
        end else begin
          read_x <= rx;
          read_y <= ry;
        end
      end
      default: ;
    endcase
  end
endmodule

>>> hdl/bilinear_current_deposit_unit.sv
// Top level of the bilinear current deposit unit: config registers, front
// and back ends. Depends on bcd_pkg, bcd_front, bcd_back and the macros.
`include "bilinear_current_deposit_unit_macros.svh"
// Each word gives one result. A deposit holds the back end from acceptance
// to the result: accept, four corner read-modify-writes on the single-port
// grid RAMs (read, wait with weight multiply, current multiply, write) and
// output. Reads and clears pass through accept, read, wait, write and output;
// dropped and unused words go from accept straight to output. The output
// state holds while the receiver holds off. The front end locates the next
// word meanwhile and holds up to two words. After reset the back end clears
// both grids, one address a cycle over all 4096 addresses (grid size); words
// wait until it is done.
module bilinear_current_deposit_unit import bcd_pkg::*; #(
  parameter int BLOCK_X = 63,
  parameter int BLOCK_Y = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [23:0] current_x,
  input  logic signed [23:0] current_y,
  input  logic [5:0]  cell_x,
  input  logic [5:0]  cell_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] read_x,
  output logic signed [31:0] read_y,
  output logic [1:0]  status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  logic signed [31:0] origin_x, origin_y;
  logic [23:0] inv_spacing_x, inv_spacing_y;
  logic q_valid, q_ready;
  job_t q_job;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      inv_spacing_x <= 24'd65536;
      inv_spacing_y <= 24'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORG_X: origin_x <= cfg_data;
        REG_ORG_Y: origin_y <= cfg_data;
        REG_INV_X: inv_spacing_x <= cfg_data[23:0];
        REG_INV_Y: inv_spacing_y <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  bcd_front #(.BLOCK_X(BLOCK_X), .BLOCK_Y(BLOCK_Y)) u_front (
    .clk, .rst, .in_valid, .in_ready, .cmd, .pos_x, .pos_y, .current_x,
    .current_y, .cell_x, .cell_y, .origin_x, .origin_y, .inv_spacing_x,
    .inv_spacing_y, .q_valid, .q_ready, .q_job);

  bcd_back #(.BLOCK_X(BLOCK_X), .BLOCK_Y(BLOCK_Y)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_job, .out_valid, .out_ready,
    .read_x, .read_y, .status);

  `BCD_ASSERT(a_status_code, !out_valid || status != 2'd3, "bad status code")
  `BCD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
  `BCD_ASSERT(a_q_take, !(q_ready && out_valid), "back end takes word while busy")
endmodule
